@@ hdl/ftca_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the flow table admission core.
// No dependencies; every other file of the block imports this package.
package ftca_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int OUT_CNT_W   = 9;
	localparam int CMP_W       = (CNT_W > OUT_CNT_W) ? CNT_W : OUT_CNT_W;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_FLOWS    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT = 1'b1;
	localparam logic [8:0]  MAX_FLOWS_RESET    = 9'd256;
	localparam logic [31:0] IDLE_TIMEOUT_RESET = 32'd1000;

	// item function codes
	localparam logic FUNC_PACKET = 1'b0;
	localparam logic FUNC_SWEEP  = 1'b1;

	typedef struct packed {
		logic        func;
		logic [31:0] source_address;
		logic [31:0] destination_address;
		logic [7:0]  priority_req;
		logic [15:0] flow_id;
		logic [31:0] now_time;
	} in_item_t;

	typedef struct packed {
		logic                 admitted;
		logic                 new_flow;
		logic [OUT_CNT_W-1:0] active_flows;
		logic [OUT_CNT_W-1:0] expired_count;
	} out_item_t;

	typedef struct packed {
		logic [63:0] addresses;
		logic [23:0] tag;
		logic [31:0] last_seen;
	} entry_t;

	// requests from the walk sequencer to the table
	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		entry_t           wr_data;
		logic             wr_set;
		logic             clr_en;
		logic [IDX_W-1:0] clr_addr;
	} tbl_cmd_t;

	typedef struct packed {
		entry_t entry;
		logic   valid;
	} tbl_rsp_t;

endpackage

@@ hdl/flow_table_count_admission_core.sv @@
`timescale 1ns / 1ps
// Flow-count admission core with idle timeout. Flows live in a 256-entry
// table memory that is scanned one entry per cycle. A packet item whose flow
// is found stops the scan at that slot. A packet of an unknown flow and a
// sweep item both scan the whole table. The scan runs over the single read
// port of the table memory, and a stalled output holds back the result.
// One item is in work at a time; the next item is taken in the cycle after
// the result is loaded into the output register, and that load waits while an
// earlier result is held by a stall. The table is empty after reset with no
// clearing pass.
// Depends on ftca_pkg, ftca_table and ftca_walk.
module flow_table_count_admission_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  ftca_pkg::in_item_t                  in_item,
	output logic                                out_valid,
	input  logic                                out_stall,
	output ftca_pkg::out_item_t                 out_item,
	input  logic                                cfg_we,
	input  logic [ftca_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ftca_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import ftca_pkg::*;

	logic [8:0]  max_flows_q;
	logic [31:0] idle_timeout_q;
	tbl_cmd_t    cmd;
	tbl_rsp_t    rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_flows_q    <= MAX_FLOWS_RESET;
			idle_timeout_q <= IDLE_TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_FLOWS:    max_flows_q    <= cfg_data[8:0];
				REG_IDLE_TIMEOUT: idle_timeout_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	ftca_walk u_walk (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_item      (in_item),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_item     (out_item),
		.max_flows    (max_flows_q),
		.idle_timeout (idle_timeout_q),
		.cmd          (cmd),
		.rsp          (rsp)
	);

	ftca_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp)
	);

endmodule

@@ hdl/ftca_table.sv @@
`timescale 1ns / 1ps
// Flow table storage: one synchronous entry memory plus per-entry valid flops.
// Depends on ftca_pkg for the entry and request types.
module ftca_table (
	input  logic              clk,
	input  logic              arst_n,
	input  ftca_pkg::tbl_cmd_t cmd,
	output ftca_pkg::tbl_rsp_t rsp
);
	import ftca_pkg::*;

	entry_t                 mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] valid_q;
	entry_t                 rd_entry_q;
	logic                   rd_valid_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[cmd.wr_addr] <= cmd.wr_data;
		end
		if (cmd.rd_en) begin
			rd_entry_q <= mem[cmd.rd_addr];
			rd_valid_q <= valid_q[cmd.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (cmd.wr_en && cmd.wr_set) begin
				valid_q[cmd.wr_addr] <= 1'b1;
			end
			if (cmd.clr_en) begin
				valid_q[cmd.clr_addr] <= 1'b0;
			end
		end
	end

	assign rsp.entry = rd_entry_q;
	assign rsp.valid = rd_valid_q;

endmodule

@@ hdl/ftca_walk.sv @@
`timescale 1ns / 1ps
// Walk sequencer: scans the flow table one entry a cycle for lookup or sweep,
// then writes back, updates the flow count and holds the result item.
// Depends on ftca_pkg and drives ftca_table through a request struct.
module ftca_walk (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  ftca_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output ftca_pkg::out_item_t out_item,
	input  logic [8:0]          max_flows,
	input  logic [31:0]         idle_timeout,
	output ftca_pkg::tbl_cmd_t  cmd,
	input  ftca_pkg::tbl_rsp_t  rsp
);
	import ftca_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_WALK   = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t           state_q;
	in_item_t         item_q;
	logic [IDX_W:0]   idx_q;
	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic             free_found_q;
	logic [IDX_W-1:0] free_idx_q;
	logic [CNT_W-1:0] removed_q;
	logic [CNT_W-1:0] count_q;
	logic             out_valid_q;
	out_item_t        out_item_q;

	logic             is_sweep;
	logic             issue;
	logic             key_match;
	logic [31:0]      elapsed;
	logic             expire;
	logic             last_entry;
	logic             out_free;
	logic             finish_go;
	logic             admit_new;
	logic [CNT_W-1:0] count_next;
	out_item_t        result;

	always_comb begin
		is_sweep   = (item_q.func == FUNC_SWEEP);
		issue      = (state_q == ST_WALK) && !idx_q[IDX_W];
		key_match  = rsp.valid
			&& (rsp.entry.addresses == {item_q.source_address, item_q.destination_address})
			&& (rsp.entry.tag == {item_q.priority_req, item_q.flow_id});
		elapsed    = item_q.now_time - rsp.entry.last_seen;
		expire     = rsp.valid && (elapsed >= idle_timeout);
		last_entry = (idx_s1 == IDX_W'(TABLE_DEPTH - 1));
		out_free   = !out_valid_q || !out_stall;
		finish_go  = (state_q == ST_FINISH) && out_free;
		admit_new  = !hit_q && free_found_q && (CMP_W'(count_q) < CMP_W'(max_flows));

		priority if (is_sweep) begin
			count_next = count_q - removed_q;
		end else if (admit_new) begin
			count_next = count_q + CNT_W'(1);
		end else begin
			count_next = count_q;
		end

		result.admitted      = !is_sweep && (hit_q || admit_new);
		result.new_flow      = !is_sweep && !hit_q;
		result.active_flows  = OUT_CNT_W'(count_next);
		result.expired_count = is_sweep ? OUT_CNT_W'(removed_q) : '0;

		cmd.rd_en               = issue;
		cmd.rd_addr             = idx_q[IDX_W-1:0];
		cmd.wr_en               = finish_go && !is_sweep && (hit_q || admit_new);
		cmd.wr_addr             = hit_q ? hit_idx_q : free_idx_q;
		cmd.wr_data.addresses   = {item_q.source_address, item_q.destination_address};
		cmd.wr_data.tag         = {item_q.priority_req, item_q.flow_id};
		cmd.wr_data.last_seen   = item_q.now_time;
		cmd.wr_set              = !hit_q;
		cmd.clr_en              = (state_q == ST_WALK) && vld_s1 && is_sweep && expire;
		cmd.clr_addr            = idx_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			vld_s1       <= 1'b0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			removed_q    <= '0;
			count_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					vld_s1 <= 1'b0;
					if (in_valid) begin
						idx_q        <= '0;
						hit_q        <= 1'b0;
						free_found_q <= 1'b0;
						removed_q    <= '0;
						state_q      <= ST_WALK;
					end
				end
				ST_WALK: begin
					vld_s1 <= issue;
					if (issue) begin
						idx_q <= idx_q + (IDX_W+1)'(1);
					end
					if (vld_s1) begin
						if (is_sweep) begin
							if (expire) begin
								removed_q <= removed_q + CNT_W'(1);
							end
						end else if (key_match) begin
							hit_q   <= 1'b1;
							state_q <= ST_FINISH;
						end else if (!rsp.valid && !free_found_q) begin
							free_found_q <= 1'b1;
						end
						if (last_entry) begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_FINISH: begin
					// drop any read still in flight after an early hit
					vld_s1 <= 1'b0;
					if (out_free) begin
						count_q <= count_next;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (finish_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && in_valid) begin
			item_q <= in_item;
		end
		idx_s1 <= idx_q[IDX_W-1:0];
		if ((state_q == ST_WALK) && vld_s1 && !is_sweep) begin
			if (key_match) begin
				hit_idx_q <= idx_s1;
			end else if (!rsp.valid && !free_found_q) begin
				free_idx_q <= idx_s1;
			end
		end
		if (finish_go) begin
			out_item_q <= result;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule
